// ===== sv/swap_to_front_search_table_defines.svh =====
// Assertion macros for the swap-to-front search table.
// Included by the top level; no other dependencies.
`ifndef SWAP_TO_FRONT_SEARCH_TABLE_DEFINES_SVH
`define SWAP_TO_FRONT_SEARCH_TABLE_DEFINES_SVH

// same-cycle implication
`define STFST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define STFST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/stfst_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// swap-to-front search table. No dependencies.
package stfst_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int DATA_W        = 32;
   localparam int SLOT_W        = 10;
   localparam int POS_W         = 10;
   localparam int CFG_W         = 11;

   typedef struct packed {
      logic start;
      logic load_wr;
      logic scan;
      logic swap_hi;
      logic swap_lo;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic hit;
      logic hit_zero;
      logic miss;
   } dp_status_type;

endpackage

// ===== sv/swap_to_front_search_table.sv =====
// Top level of the swap-to-front search table: controller plus datapath.
// Depends on stfst_pkg, stfst_ctrl, stfst_datapath and the defines header.
//
// A load beat writes one table slot (a slot at or above DEPTH is ignored). A
// search beat walks the table RAM from slot 0 through its single read port,
// one entry per cycle, over n = min(entries_in_use, DEPTH) slots, stopping
// at the first hit. A miss or a hit at slot 0 goes straight to the result; a
// hit at slot i > 0 first makes the two swap writes through the one write
// port; a search also waits while an earlier result is still held off.
// Results sit in an output register, so load beats keep flowing while a result
// waits. There is no clearing pass: slots read by a search must have been
// loaded first.
`include "swap_to_front_search_table_defines.svh"

module swap_to_front_search_table #(
   parameter int DEPTH = stfst_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [stfst_pkg::CFG_W-1:0]         csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [stfst_pkg::SLOT_W-1:0]        req_slot,
   input  logic signed [stfst_pkg::DATA_W-1:0] req_entry_value,
   input  logic signed [stfst_pkg::DATA_W-1:0] req_search_key,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [stfst_pkg::POS_W-1:0]         rsp_position
);

   stfst_pkg::dp_cmd_type    cmd;
   stfst_pkg::dp_status_type status;

   stfst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   stfst_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_slot         (req_slot),
      .req_entry_value  (req_entry_value),
      .req_search_key   (req_search_key),
      .rsp_found        (rsp_found),
      .rsp_position     (rsp_position),
      .cmd              (cmd),
      .status           (status)
   );

   `STFST_ASSERT_NEXT(a_search_busy, clock, reset, req_valid && !req_stall && req_mode, req_stall, "search beat did not hold off the next request")
   `STFST_ASSERT_NEXT(a_load_single, clock, reset, req_valid && !req_stall && !req_mode, !req_stall, "load beat took more than one cycle")
   `STFST_ASSERT_NOW(a_rsp_after_search, clock, reset, $rose(rsp_valid), $past(req_stall), "result raised without a search in progress")

endmodule

// ===== sv/stfst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stfst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/stfst_ctrl.sv =====
// Sequencer for load, scan, swap and result beats of the search table.
// Depends on stfst_pkg for the command and status types.
module stfst_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_mode,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  stfst_pkg::dp_status_type status,
   output stfst_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      SWAP_HI,
      SWAP_LO,
      RESULT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      out_free;

   always_comb begin
      accept       = (state_ff == IDLE) && req_valid;
      out_free     = !rsp_valid_ff || !rsp_stall;
      cmd          = '0;
      cmd.start    = accept && req_mode;
      cmd.load_wr  = accept && !req_mode;
      cmd.scan     = (state_ff == SCAN);
      cmd.swap_hi  = (state_ff == SWAP_HI);
      cmd.swap_lo  = (state_ff == SWAP_LO);
      cmd.load_rsp = (state_ff == RESULT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (cmd.start) begin
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               priority if (status.hit) begin
                  state_ff <= status.hit_zero ? RESULT : SWAP_HI;
               end else if (status.miss) begin
                  state_ff <= RESULT;
               end else begin
                  state_ff <= SCAN;
               end
            end
            SWAP_HI: begin
               state_ff <= SWAP_LO;
            end
            SWAP_LO: begin
               state_ff <= RESULT;
            end
            RESULT: begin
               if (out_free) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/stfst_datapath.sv =====
// Table storage, scan pipeline, swap writes and result registers.
// Depends on stfst_pkg and stfst_ram.
module stfst_datapath #(
   parameter int DEPTH = stfst_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [stfst_pkg::CFG_W-1:0]        csr_write_data,
   input  logic [stfst_pkg::SLOT_W-1:0]       req_slot,
   input  logic signed [stfst_pkg::DATA_W-1:0] req_entry_value,
   input  logic signed [stfst_pkg::DATA_W-1:0] req_search_key,
   output logic                               rsp_found,
   output logic [stfst_pkg::POS_W-1:0]        rsp_position,
   input  stfst_pkg::dp_cmd_type              cmd,
   output stfst_pkg::dp_status_type           status
);

   localparam int AW  = $clog2(DEPTH);
   localparam int LW  = AW + 1;
   localparam int CW  = (LW > stfst_pkg::CFG_W) ? LW : stfst_pkg::CFG_W;
   localparam int SCW = (LW > stfst_pkg::SLOT_W) ? LW : stfst_pkg::SLOT_W;
   localparam int PW  = stfst_pkg::POS_W;
   localparam int DW  = stfst_pkg::DATA_W;

   logic [stfst_pkg::CFG_W-1:0] entries_ff;
   logic [DW-1:0]               key_ff;
   logic [DW-1:0]               head_ff;
   logic [LW-1:0]               limit_ff;
   logic [LW-1:0]               limit_in;
   logic [LW-1:0]               rd_idx_ff;
   logic [AW-1:0]               cmp_idx_ff;
   logic                        cmp_valid_ff;
   logic                        res_found_ff;
   logic [AW-1:0]               res_pos_ff;
   logic                        rsp_found_ff;
   logic [PW-1:0]               rsp_position_ff;

   logic [CW-1:0]  ent_ext;
   logic [CW-1:0]  depth_ext;
   logic           slot_ok;
   logic           rd_go;
   logic [DW-1:0]  ram_rdata;
   logic           ram_wr_en;
   logic [AW-1:0]  ram_wr_addr;
   logic [DW-1:0]  ram_wr_data;
   logic           hit;

   always_comb begin
      ent_ext   = CW'(entries_ff);
      depth_ext = CW'(DEPTH);
      limit_in  = (ent_ext < depth_ext) ? LW'(ent_ext) : LW'(depth_ext);
      slot_ok   = SCW'(req_slot) < SCW'(DEPTH);
      rd_go     = cmd.scan && (rd_idx_ff < limit_ff);
      hit       = cmp_valid_ff && (ram_rdata == key_ff);

      status          = '0;
      status.hit      = hit;
      status.hit_zero = hit && (cmp_idx_ff == '0);
      status.miss     = !cmp_valid_ff && (rd_idx_ff >= limit_ff);

      priority if (cmd.load_wr) begin
         ram_wr_en   = slot_ok;
         ram_wr_addr = AW'(req_slot);
         ram_wr_data = req_entry_value;
      end else if (cmd.swap_hi) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = res_pos_ff;
         ram_wr_data = head_ff;
      end else if (cmd.swap_lo) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = '0;
         ram_wr_data = key_ff;
      end else begin
         ram_wr_en   = 1'b0;
         ram_wr_addr = '0;
         ram_wr_data = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff   <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            entries_ff <= csr_write_data;
         end
         cmp_valid_ff <= rd_go;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff    <= req_search_key;
         limit_ff  <= limit_in;
         rd_idx_ff <= '0;
      end else if (rd_go) begin
         rd_idx_ff <= rd_idx_ff + LW'(1);
      end
      if (rd_go) begin
         cmp_idx_ff <= rd_idx_ff[AW-1:0];
      end
      // mirror of slot 0 for the swap write
      if (cmd.load_wr && slot_ok && (req_slot == '0)) begin
         head_ff <= req_entry_value;
      end else if (cmd.swap_lo) begin
         head_ff <= key_ff;
      end
      if (cmd.scan && (status.hit || status.miss)) begin
         res_found_ff <= hit;
         res_pos_ff   <= hit ? cmp_idx_ff : '0;
      end
      if (cmd.load_rsp) begin
         rsp_found_ff    <= res_found_ff;
         rsp_position_ff <= PW'(res_pos_ff);
      end
   end

   stfst_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (rd_go),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule
